### sv/smf_pkg.sv
// smf_pkg: request/result payload types, status codes and defaults for the
// segmenting message FIFO. No dependencies; every other file imports it.

package smf_pkg;

    // Build defaults for the top-level parameters
    localparam int SLOT_BYTES_DEF = 16;
    localparam int SLOTS_LOG2_DEF = 4;

    // Configuration register
    localparam int            CFG_W     = 3;
    localparam logic [CFG_W-1:0] CFG_RESET = 3'd4;

    // Request queue between the front and the ring engine
    localparam int QUEUE_DEPTH = 2;

    // Request kinds
    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_PUSH_OK   = 2'd0;
    localparam logic [1:0] ST_PUSH_DROP = 2'd1;
    localparam logic [1:0] ST_POP_EMPTY = 2'd2;
    localparam logic [1:0] ST_POP_DATA  = 2'd3;

    typedef struct packed {
        logic        req_type;
        logic [31:0] conn_id;
        logic [7:0]  data_byte;
        logic        message_end;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] slot_conn;
        logic        first_segment;
        logic        more_segments;
        logic [7:0]  out_byte;
        logic        last_of_run;
        logic        ring_readable;
    } t_result;

    // Queue head as seen by the engine
    typedef struct packed {
        logic valid;
        t_req req;
    } t_queue_head;

endpackage

### sv/smf_req_queue.sv
// smf_req_queue: short request queue that decouples command intake from the
// ring engine. Depends on smf_pkg.

module smf_req_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  smf_pkg::t_req        i_req,
    output logic                 o_full,
    output logic                 o_empty,
    output smf_pkg::t_queue_head o_head,
    input  logic                 i_take
);
    import smf_pkg::*;

    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    t_req           r_mem [QUEUE_DEPTH];
    logic [QAW-1:0] r_wr_ptr, n_wr_ptr;
    logic [QAW-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCW-1:0] r_count,  n_count;
    logic           do_push, do_take;

    assign o_full       = (r_count == QCW'(QUEUE_DEPTH));
    assign o_empty      = (r_count == '0);
    assign o_head.valid = !o_empty;
    assign o_head.req   = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_full;
    assign do_take = i_take && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_take) begin
            n_rd_ptr = (r_rd_ptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_take) begin
            n_count = r_count + 1'b1;
        end else if (do_take && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_req;
        end
    end

endmodule

### sv/smf_ring_engine.sv
// smf_ring_engine: slot ring with payload and slot-record memories; executes
// push and pop requests and drives the result register. Depends on smf_pkg.

module smf_ring_engine #(
    parameter int SLOT_BYTES = smf_pkg::SLOT_BYTES_DEF,
    parameter int SLOTS_LOG2 = smf_pkg::SLOTS_LOG2_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  smf_pkg::t_queue_head     i_head,
    output logic                     o_take,
    output logic                     o_idle,
    input  logic                     i_cfg_we,
    input  logic [smf_pkg::CFG_W-1:0] i_cfg_data,
    output logic                     o_res_valid,
    output smf_pkg::t_result         o_res
);
    import smf_pkg::*;

    localparam int DEPTH = 1 << SLOTS_LOG2;
    localparam int PW    = SLOTS_LOG2 + 1;
    localparam int FW    = $clog2(SLOT_BYTES + 1);
    localparam int AW    = $clog2(DEPTH * SLOT_BYTES) > 0 ? $clog2(DEPTH * SLOT_BYTES) : 1;

    typedef struct packed {
        logic [31:0]   conn;
        logic          first;
        logic          more;
        logic [FW-1:0] len;
    } t_meta;

    typedef enum logic {
        S_IDLE,
        S_POP_DATA
    } t_state;

    // Memories
    logic [7:0] r_payload [DEPTH * SLOT_BYTES];
    t_meta      r_meta    [DEPTH];
    logic [7:0] r_byte_q;
    t_meta      r_meta_q;

    // Control state
    t_state            r_state,  n_state;
    logic [PW-1:0]     r_wr_pos, n_wr_pos;
    logic [PW-1:0]     r_rd_pos, n_rd_pos;
    logic [FW-1:0]     r_fill,   n_fill;
    logic              r_inside, n_inside;
    logic              r_drop,   n_drop;
    logic [CFG_W-1:0]  r_cfg,    n_cfg;
    logic [31:0]       r_seg_conn,  n_seg_conn;
    logic              r_seg_first, n_seg_first;
    logic [SLOTS_LOG2-1:0] r_pop_slot, n_pop_slot;
    logic [FW-1:0]     r_idx,    n_idx;
    logic              r_res_valid, n_res_valid;
    t_result           r_res,    n_res;

    // Memory ports
    logic              pay_we, pay_re, meta_we, meta_re;
    logic [AW-1:0]     pay_waddr, pay_raddr;
    logic [7:0]        pay_wdata;
    logic [SLOTS_LOG2-1:0] meta_waddr, meta_raddr;
    t_meta             meta_wdata;

    // Ring geometry
    logic [3:0]            lg_ext, lg_sat;
    logic [PW-1:0]         cap;
    logic [SLOTS_LOG2-1:0] slot_mask, wr_slot, rd_slot;
    logic [PW-1:0]         used, used_after;
    logic [FW-1:0]         fill_inc;
    logic                  seg_first_eff;
    logic [31:0]           seg_conn_eff;

    always_comb begin
        lg_ext = {{(4 - CFG_W){1'b0}}, r_cfg};
        if (lg_ext < 4'd1) begin
            lg_sat = 4'd1;
        end else if (lg_ext > 4'(SLOTS_LOG2)) begin
            lg_sat = 4'(SLOTS_LOG2);
        end else begin
            lg_sat = lg_ext;
        end
    end

    assign cap       = PW'(1) << lg_sat;
    assign slot_mask = SLOTS_LOG2'(cap - PW'(1));
    assign wr_slot   = r_wr_pos[SLOTS_LOG2-1:0] & slot_mask;
    assign rd_slot   = r_rd_pos[SLOTS_LOG2-1:0] & slot_mask;
    assign used      = r_wr_pos - r_rd_pos;
    assign used_after = n_wr_pos - n_rd_pos;
    assign fill_inc  = r_fill + 1'b1;
    assign seg_conn_eff  = (r_fill == '0) ? i_head.req.conn_id : r_seg_conn;
    assign seg_first_eff = (r_fill == '0) ? !r_inside : r_seg_first;

    assign o_take      = (r_state == S_IDLE) && i_head.valid;
    assign o_idle      = (r_state == S_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    always_comb begin
        n_state     = r_state;
        n_wr_pos    = r_wr_pos;
        n_rd_pos    = r_rd_pos;
        n_fill      = r_fill;
        n_inside    = r_inside;
        n_drop      = r_drop;
        n_cfg       = r_cfg;
        n_seg_conn  = r_seg_conn;
        n_seg_first = r_seg_first;
        n_pop_slot  = r_pop_slot;
        n_idx       = r_idx;
        n_res_valid = 1'b0;
        n_res       = '0;

        pay_we     = 1'b0;
        pay_waddr  = AW'(wr_slot) * AW'(SLOT_BYTES) + AW'(r_fill);
        pay_wdata  = i_head.req.data_byte;
        pay_re     = 1'b0;
        pay_raddr  = AW'(rd_slot) * AW'(SLOT_BYTES);
        meta_we    = 1'b0;
        meta_waddr = wr_slot;
        meta_wdata = '{conn: seg_conn_eff, first: seg_first_eff,
                       more: !i_head.req.message_end, len: fill_inc};
        meta_re    = 1'b0;
        meta_raddr = rd_slot;

        if (i_cfg_we) begin
            // Any register write empties the ring
            n_cfg    = i_cfg_data;
            n_wr_pos = '0;
            n_rd_pos = '0;
            n_fill   = '0;
            n_inside = 1'b0;
            n_drop   = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_head.valid && i_head.req.req_type == REQ_PUSH) begin
                    n_res_valid = 1'b1;
                    n_res.status = ST_PUSH_OK;
                    if (r_drop) begin
                        n_res.status = ST_PUSH_DROP;
                        if (i_head.req.message_end) begin
                            n_drop   = 1'b0;
                            n_inside = 1'b0;
                        end
                    end else if (r_fill == '0 && used >= cap) begin
                        n_res.status = ST_PUSH_DROP;
                        if (i_head.req.message_end) begin
                            n_inside = 1'b0;
                        end else begin
                            n_drop = 1'b1;
                        end
                    end else begin
                        pay_we      = 1'b1;
                        n_seg_conn  = seg_conn_eff;
                        n_seg_first = seg_first_eff;
                        n_fill      = fill_inc;
                        if (fill_inc == FW'(SLOT_BYTES) || i_head.req.message_end) begin
                            // Publish the slot
                            meta_we  = 1'b1;
                            n_wr_pos = r_wr_pos + 1'b1;
                            n_fill   = '0;
                            n_inside = !i_head.req.message_end;
                        end
                    end
                    n_res.last_of_run   = 1'b1;
                    n_res.ring_readable = (used_after != '0);
                end else if (i_head.valid) begin
                    if (used == '0) begin
                        n_res_valid       = 1'b1;
                        n_res.status      = ST_POP_EMPTY;
                        n_res.last_of_run = 1'b1;
                    end else begin
                        // Fetch the slot record and its first byte
                        meta_re    = 1'b1;
                        pay_re     = 1'b1;
                        n_pop_slot = rd_slot;
                        n_rd_pos   = r_rd_pos + 1'b1;
                        n_idx      = '0;
                        n_state    = S_POP_DATA;
                    end
                end
            end
            S_POP_DATA: begin
                n_res_valid         = 1'b1;
                n_res.status        = ST_POP_DATA;
                n_res.slot_conn     = r_meta_q.conn;
                n_res.first_segment = r_meta_q.first;
                n_res.more_segments = r_meta_q.more;
                n_res.out_byte      = r_byte_q;
                n_res.ring_readable = (used != '0);
                if (r_idx + 1'b1 >= r_meta_q.len) begin
                    n_res.last_of_run = 1'b1;
                    n_state           = S_IDLE;
                end else begin
                    pay_re    = 1'b1;
                    pay_raddr = AW'(r_pop_slot) * AW'(SLOT_BYTES) + AW'(r_idx + 1'b1);
                    n_idx     = r_idx + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wr_pos    <= '0;
            r_rd_pos    <= '0;
            r_fill      <= '0;
            r_inside    <= 1'b0;
            r_drop      <= 1'b0;
            r_cfg       <= CFG_RESET;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wr_pos    <= n_wr_pos;
            r_rd_pos    <= n_rd_pos;
            r_fill      <= n_fill;
            r_inside    <= n_inside;
            r_drop      <= n_drop;
            r_cfg       <= n_cfg;
            r_res_valid <= n_res_valid;
        end
        r_seg_conn  <= n_seg_conn;
        r_seg_first <= n_seg_first;
        r_pop_slot  <= n_pop_slot;
        r_idx       <= n_idx;
        r_res       <= n_res;
    end

    // Payload memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (pay_we) begin
            r_payload[pay_waddr] <= pay_wdata;
        end
        if (pay_re) begin
            r_byte_q <= r_payload[pay_raddr];
        end
    end

    // Slot record memory: written on publish, read at pop start
    always_ff @(posedge i_clk) begin
        if (meta_we) begin
            r_meta[meta_waddr] <= meta_wdata;
        end
        if (meta_re) begin
            r_meta_q <= r_meta[meta_raddr];
        end
    end

endmodule

### sv/segmenting_message_fifo.sv
// segmenting_message_fifo: top level; request queue in front of the ring engine.
// Depends on smf_pkg, smf_req_queue and smf_ring_engine.
//
//  channel   direction  handshake                     payload
//  --------  ---------  ----------------------------  ----------------
//  request   in         start high, busy low          i_req (t_req)
//  result    out        o_res_valid strobe, 1 cycle   o_res (t_result)
//  config    in         i_cfg_valid and o_cfg_ready   i_cfg_data (3 b)
//
// A push and an empty pop each yield one result. A pop of data reads the slot
// record with its first byte, then the remaining payload bytes one at a time
// through the single read port of the payload memory.
// Results are registered in the engine before they reach o_res.
// Reset is synchronous; the ring comes up empty, no clearing pass.
// busy rises only when the request queue is full; the receiver cannot stall
// results, so the engine never waits on the output side.

module segmenting_message_fifo #(
    parameter int SLOT_BYTES = smf_pkg::SLOT_BYTES_DEF,
    parameter int SLOTS_LOG2 = smf_pkg::SLOTS_LOG2_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // request channel
    input  logic                      start,
    output logic                      busy,
    input  smf_pkg::t_req             i_req,
    // result channel
    output logic                      o_res_valid,
    output smf_pkg::t_result          o_res,
    // configuration channel
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [smf_pkg::CFG_W-1:0] i_cfg_data
);
    import smf_pkg::*;

    logic        q_full;
    logic        q_empty;
    logic        eng_take;
    logic        eng_idle;
    t_queue_head q_head;

    assign busy = q_full;

    // Accept a config write only with no request queued or in flight
    assign o_cfg_ready = q_empty && eng_idle;

    // Front: hold requests until the engine is free
    smf_req_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (start),
        .i_req   (i_req),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head),
        .i_take  (eng_take)
    );

    // Back: advance the ring, emit one result per push, per empty pop and per popped byte
    smf_ring_engine #(
        .SLOT_BYTES (SLOT_BYTES),
        .SLOTS_LOG2 (SLOTS_LOG2)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (q_head),
        .o_take      (eng_take),
        .o_idle      (eng_idle),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

endmodule

### dv/segmenting_message_fifo_tb.sv
`timescale 1ns / 1ps
// segmenting_message_fifo_tb: self-checking testbench with a scripted opening and random phases.
// Depends on smf_pkg and segmenting_message_fifo; results are checked against a ring predictor.

module segmenting_message_fifo_tb;
    import smf_pkg::*;

    localparam int SLOT_BYTES  = SLOT_BYTES_DEF;
    localparam int SLOTS_LOG2  = SLOTS_LOG2_DEF;
    localparam int RING_DEPTH  = 1 << SLOTS_LOG2;
    localparam int MAX_SHOWN   = 10;
    localparam int PHASE_ITEMS = 52;
    localparam int DRAIN_LIMIT = 5000;

    // One line of the opening script: a register write, or a request repeated
    // reps times (bytes count up, the end mark goes on the last copy only).
    // Rows with fixed set carry their single expected result typed in.
    typedef struct {
        bit               is_write;
        logic [CFG_W-1:0] write_value;
        t_req             req;
        int               reps;
        bit               fixed;
        t_result          want;
    } t_script_row;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             start       = 1'b0;
    logic             busy;
    t_req             i_req       = '0;
    logic             o_res_valid;
    t_result          o_res;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [CFG_W-1:0] i_cfg_data  = '0;

    // Typed expectation that rides along with the request on the port
    logic    tag_fixed = 1'b0;
    t_result tag_want  = '0;

    // Predictor copy of the ring
    logic [7:0]          ring_payload [RING_DEPTH*SLOT_BYTES];
    logic [31:0]         ring_conn    [RING_DEPTH];
    int                  ring_len     [RING_DEPTH];
    logic                ring_first   [RING_DEPTH];
    logic                ring_more    [RING_DEPTH];
    logic [SLOTS_LOG2:0] ring_wr_pos;
    logic [SLOTS_LOG2:0] ring_rd_pos;
    int                  ring_fill;
    logic                ring_in_msg;
    logic                ring_dropping;
    logic [CFG_W-1:0]    ring_slot_log2;

    t_result     awaited_results [$];
    t_script_row opening_script  [$];
    int          mismatch_count = 0;
    bit          idle_on        = 1'b1;

    segmenting_message_fifo #(
        .SLOT_BYTES (SLOT_BYTES),
        .SLOTS_LOG2 (SLOTS_LOG2)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop well past the slowest legal run
    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Slot count in use; out-of-range register values saturate into 1..SLOTS_LOG2
    function automatic int ring_capacity();
        int lg;
        lg = ring_slot_log2;
        if (lg < 1) lg = 1;
        if (lg > SLOTS_LOG2) lg = SLOTS_LOG2;
        return 1 << lg;
    endfunction

    // Reset and every register write leave the ring empty with no open message
    function automatic void empty_ring_model();
        ring_wr_pos   = '0;
        ring_rd_pos   = '0;
        ring_fill     = 0;
        ring_in_msg   = 1'b0;
        ring_dropping = 1'b0;
    endfunction

    // Advance the ring copy by one request and queue the results it causes.
    // A typed expectation replaces the computed one on single-result requests.
    function automatic void compute_ring_results(t_req r, logic fixed, t_result want);
        int                  cap;
        int                  slot;
        logic [SLOTS_LOG2:0] used;
        t_result             res;
        cap  = ring_capacity();
        used = ring_wr_pos - ring_rd_pos;
        res  = '0;
        res.last_of_run = 1'b1;
        if (r.req_type == REQ_PUSH) begin
            res.status = ST_PUSH_OK;
            if (ring_dropping) begin
                // Swallow the tail of a message that hit a full ring
                res.status = ST_PUSH_DROP;
                if (r.message_end) begin
                    ring_dropping = 1'b0;
                    ring_in_msg   = 1'b0;
                end
            end else if (ring_fill == 0 && used >= cap) begin
                // No room for a new segment: drop, and keep dropping unless this ends it
                res.status = ST_PUSH_DROP;
                if (r.message_end) ring_in_msg = 1'b0;
                else ring_dropping = 1'b1;
            end else begin
                slot = int'(ring_wr_pos) & (cap - 1);
                // The first byte of a segment fixes its connection id
                if (ring_fill == 0) begin
                    ring_conn[slot]  = r.conn_id;
                    ring_first[slot] = !ring_in_msg;
                end
                ring_payload[slot*SLOT_BYTES + ring_fill] = r.data_byte;
                ring_fill++;
                // Publish on a full slot or on the end mark
                if (ring_fill >= SLOT_BYTES || r.message_end) begin
                    ring_len[slot]  = ring_fill;
                    ring_more[slot] = !r.message_end;
                    ring_wr_pos++;
                    ring_fill   = 0;
                    ring_in_msg = !r.message_end;
                end
            end
            res.ring_readable = (ring_wr_pos != ring_rd_pos);
            awaited_results.push_back(fixed ? want : res);
        end else if (used == 0) begin
            // A slot still filling does not count as readable
            res.status = ST_POP_EMPTY;
            awaited_results.push_back(fixed ? want : res);
        end else begin
            slot = int'(ring_rd_pos) & (cap - 1);
            ring_rd_pos++;
            res.status        = ST_POP_DATA;
            res.slot_conn     = ring_conn[slot];
            res.first_segment = ring_first[slot];
            res.more_segments = ring_more[slot];
            res.ring_readable = (ring_wr_pos != ring_rd_pos);
            for (int i = 0; i < ring_len[slot]; i++) begin
                res.out_byte    = ring_payload[slot*SLOT_BYTES + i];
                res.last_of_run = (i == ring_len[slot] - 1);
                awaited_results.push_back(res);
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    function automatic string result_text(t_result r);
        return $sformatf("status=%0d conn=%08h first=%0b more=%0b byte=%02h last=%0b readable=%0b",
                         r.status, r.slot_conn, r.first_segment, r.more_segments,
                         r.out_byte, r.last_of_run, r.ring_readable);
    endfunction

    function automatic void note_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN) $display("[%0t] %s", $time, msg);
    endfunction

    function automatic void check_result(t_result got);
        t_result want;
        string   diffs;
        if (awaited_results.size() == 0) begin
            note_mismatch($sformatf("result with none awaited: %s", result_text(got)));
            return;
        end
        want  = awaited_results.pop_front();
        diffs = "";
        if (got.status        !== want.status)        diffs = {diffs, " status"};
        if (got.slot_conn     !== want.slot_conn)     diffs = {diffs, " slot_conn"};
        if (got.first_segment !== want.first_segment) diffs = {diffs, " first_segment"};
        if (got.more_segments !== want.more_segments) diffs = {diffs, " more_segments"};
        if (got.out_byte      !== want.out_byte)      diffs = {diffs, " out_byte"};
        if (got.last_of_run   !== want.last_of_run)   diffs = {diffs, " last_of_run"};
        if (got.ring_readable !== want.ring_readable) diffs = {diffs, " ring_readable"};
        if (diffs != "")
            note_mismatch($sformatf("wrong%s\n  expected %s\n  actual   %s",
                                    diffs, result_text(want), result_text(got)));
    endfunction

    // Sample everything on the edge: check the result first, then apply a
    // register write or predict an accepted request. Both never meet.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ring_slot_log2 = CFG_RESET;
            empty_ring_model();
        end else begin
            if (o_res_valid) check_result(o_res);
            if (i_cfg_valid && o_cfg_ready) begin
                ring_slot_log2 = i_cfg_data;
                empty_ring_model();
            end
            if (start && !busy) compute_ring_results(i_req, tag_fixed, tag_want);
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // After an optional idle gap, hold start with the request until busy is low at an edge
    task automatic send_request(input t_req r, input logic fixed, input t_result want);
        int gap;
        gap = idle_on ? $urandom_range(0, 11) : 0;
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start     <= 1'b1;
        i_req     <= r;
        tag_fixed <= fixed;
        tag_want  <= want;
        do @(posedge i_clk); while (busy);
    endtask

    // Stop requesting and wait out every awaited result; the first edge lets
    // the last accepted request reach the predictor.
    task automatic wait_for_drain();
        int waited;
        waited = 0;
        start <= 1'b0;
        @(posedge i_clk);
        while (awaited_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
    endtask

    // Write the slot count only with the block idle
    task automatic write_slot_count(input logic [CFG_W-1:0] value);
        wait_for_drain();
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Opening script rows
    // ------------------------------------------------------------------

    function automatic t_script_row push_row(logic [31:0] conn, logic [7:0] data,
                                             logic last, int reps);
        t_script_row row;
        row.is_write          = 1'b0;
        row.write_value       = '0;
        row.req.req_type      = REQ_PUSH;
        row.req.conn_id       = conn;
        row.req.data_byte     = data;
        row.req.message_end   = last;
        row.reps              = reps;
        row.fixed             = 1'b0;
        row.want              = '0;
        return row;
    endfunction

    // Pop fields other than the kind are don't-care; fill them with noise
    function automatic t_script_row pop_row();
        t_script_row row;
        row = push_row($urandom, 8'($urandom), 1'($urandom), 1);
        row.req.req_type = REQ_POP;
        return row;
    endfunction

    function automatic t_script_row write_row(logic [CFG_W-1:0] value);
        t_script_row row;
        row = push_row('0, '0, 1'b0, 1);
        row.is_write    = 1'b1;
        row.write_value = value;
        return row;
    endfunction

    // Typed outcome for rows whose result needs no bookkeeping to read off
    function automatic t_script_row expect_outcome(t_script_row row, logic [1:0] status,
                                                   logic readable);
        row.fixed              = 1'b1;
        row.want               = '0;
        row.want.status        = status;
        row.want.last_of_run   = 1'b1;
        row.want.ring_readable = readable;
        return row;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    initial begin : stimulus
        t_req             r;
        int               msg_left;
        logic [31:0]      msg_conn;
        int               pop_pct;
        logic [CFG_W-1:0] phase_slot_log2 [8];

        phase_slot_log2 = '{3'd3, 3'd1, 3'd2, 3'd5, 3'd4, 3'd6, 3'd0, 3'd2};

        // Fresh ring at the reset slot count
        opening_script.push_back(expect_outcome(pop_row(), ST_POP_EMPTY, 1'b0));
        opening_script.push_back(expect_outcome(push_row(32'hFFFF_FFFF, 8'h00, 1'b0, 1),
                                                ST_PUSH_OK, 1'b0));
        // Half-filled slot is not readable yet
        opening_script.push_back(expect_outcome(pop_row(), ST_POP_EMPTY, 1'b0));
        // Different conn id mid-segment; slot keeps the first one
        opening_script.push_back(expect_outcome(push_row(32'h0000_0000, 8'hFF, 1'b1, 1),
                                                ST_PUSH_OK, 1'b1));
        opening_script.push_back(pop_row());
        // Slot count below range saturates to two slots
        opening_script.push_back(write_row(3'd0));
        // Full slot publishes with more set, then the end mark publishes the tail
        opening_script.push_back(push_row(32'hA5A5_A5A5, 8'hF0, 1'b0, SLOT_BYTES));
        opening_script.push_back(push_row(32'h5A5A_5A5A, 8'h42, 1'b1, 1));
        // Ring full at segment start: drop through the end mark
        opening_script.push_back(expect_outcome(push_row(32'h1234_5678, 8'h80, 1'b0, 1),
                                                ST_PUSH_DROP, 1'b1));
        opening_script.push_back(expect_outcome(push_row(32'h1234_5678, 8'h81, 1'b0, 1),
                                                ST_PUSH_DROP, 1'b1));
        opening_script.push_back(expect_outcome(push_row(32'h1234_5678, 8'h7F, 1'b1, 1),
                                                ST_PUSH_DROP, 1'b1));
        // Single-byte message against a full ring: dropped, no drop state left behind
        opening_script.push_back(expect_outcome(push_row(32'h8765_4321, 8'h01, 1'b1, 1),
                                                ST_PUSH_DROP, 1'b1));
        opening_script.push_back(pop_row());
        opening_script.push_back(expect_outcome(push_row(32'hCAFE_F00D, 8'h55, 1'b1, 1),
                                                ST_PUSH_OK, 1'b1));
        opening_script.push_back(pop_row());
        opening_script.push_back(pop_row());
        opening_script.push_back(expect_outcome(pop_row(), ST_POP_EMPTY, 1'b0));
        // Register write empties a ring that still holds a published slot
        opening_script.push_back(push_row(32'h0F0F_0F0F, 8'hAA, 1'b1, 1));
        opening_script.push_back(write_row(3'd7));
        opening_script.push_back(expect_outcome(pop_row(), ST_POP_EMPTY, 1'b0));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (opening_script[n]) begin
            if (opening_script[n].is_write) begin
                write_slot_count(opening_script[n].write_value);
            end else begin
                for (int k = 0; k < opening_script[n].reps; k++) begin
                    r = opening_script[n].req;
                    r.data_byte   = opening_script[n].req.data_byte + 8'(k);
                    r.message_end = opening_script[n].req.message_end
                                    && (k == opening_script[n].reps - 1);
                    send_request(r, opening_script[n].fixed, opening_script[n].want);
                end
            end
        end

        // Random phases: mostly whole messages under one conn id, with pops
        // mixed in; some messages end early or switch conn id mid-stream.
        foreach (phase_slot_log2[p]) begin
            write_slot_count(phase_slot_log2[p]);
            pop_pct  = $urandom_range(15, 60);
            idle_on  = ($urandom_range(0, 3) != 0);
            msg_left = 0;
            msg_conn = '0;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // Halfway through, drain completely and flip the idle mode
                if (i == PHASE_ITEMS / 2) begin
                    wait_for_drain();
                    idle_on = !idle_on;
                end
                r.conn_id     = $urandom;
                r.data_byte   = 8'($urandom);
                r.message_end = 1'($urandom);
                if ($urandom_range(0, 99) < pop_pct) begin
                    r.req_type = REQ_POP;
                end else begin
                    r.req_type = REQ_PUSH;
                    if (msg_left == 0) begin
                        msg_left = ($urandom_range(0, 6) == 0) ? $urandom_range(SLOT_BYTES + 1, 48)
                                                               : $urandom_range(1, 12);
                        msg_conn = $urandom;
                    end
                    if ($urandom_range(0, 9) != 0) r.conn_id = msg_conn;
                    r.message_end = (msg_left == 1) || ($urandom_range(0, 99) < 3);
                    msg_left = r.message_end ? 0 : msg_left - 1;
                end
                send_request(r, 1'b0, '0);
            end
        end

        // Let the last results land, wait on for stragglers, then check that none is still awaited
        wait_for_drain();
        repeat (SLOT_BYTES + 4) @(posedge i_clk);
        if (awaited_results.size() != 0)
            note_mismatch($sformatf("%0d results never arrived", awaited_results.size()));
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### filelist.f
sv/smf_pkg.sv
sv/smf_req_queue.sv
sv/smf_ring_engine.sv
sv/segmenting_message_fifo.sv
dv/segmenting_message_fifo_tb.sv
